// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at every edge outside reset.
`define TNH_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define TNH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define TNH_ASSERT(lbl, clk, rst, prop, msg)
`define TNH_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/tnh_pkg.sv -----
`default_nettype none

package tnh_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int ADDR_W          = 16;
  localparam int INDEX_W         = 5;
  localparam int CFG_INDEX_W     = 1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_ROUTE = 1'b1;

  localparam logic STATUS_GOOD     = 1'b0;
  localparam logic STATUS_NO_ROUTE = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_LOCAL  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_UPLINK = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_PICK,
    S_CHECK,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    RES_ZERO_OK,
    RES_UPLINK,
    RES_FOUND,
    RES_NO_ROUTE
  } res_sel_t;

  typedef struct packed {
    logic     load_item;
    logic     tbl_write;
    logic     match_en;
    logic     pick_en;
    logic     step_en;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic req_op;
    logic req_sensor;
    logic at_local;
    logic walk_over;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/tnh_in_if.sv -----
`default_nettype none

interface tnh_in_if;
  import tnh_pkg::*;

  logic               valid;
  logic               ready;
  logic               op;
  logic [INDEX_W-1:0] entry_index;
  logic [ADDR_W-1:0]  entry_node;
  logic [ADDR_W-1:0]  entry_parent;
  logic [ADDR_W-1:0]  dest_address;
  logic               is_sensor_data;

  modport source (
    output valid, op, entry_index, entry_node, entry_parent, dest_address, is_sensor_data,
    input  ready
  );

  modport sink (
    input  valid, op, entry_index, entry_node, entry_parent, dest_address, is_sensor_data,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/tnh_out_if.sv -----
`default_nettype none

interface tnh_out_if;
  import tnh_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] next_hop;
  logic              status;

  modport source (
    output valid, next_hop, status,
    input  ready
  );

  modport sink (
    input  valid, next_hop, status,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/tnh_datapath.sv -----
`default_nettype none

`include "assert_macros.svh"

module tnh_datapath #(
  parameter int TABLE_DEPTH = tnh_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [tnh_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [tnh_pkg::ADDR_W-1:0]           cfg_data,
  input  logic                                 op,
  input  logic [tnh_pkg::INDEX_W-1:0]          entry_index,
  input  logic [tnh_pkg::ADDR_W-1:0]           entry_node,
  input  logic [tnh_pkg::ADDR_W-1:0]           entry_parent,
  input  logic [tnh_pkg::ADDR_W-1:0]           dest_address,
  input  logic                                 is_sensor_data,
  input  tnh_pkg::cmd_t                        cmd,
  output tnh_pkg::sts_t                        sts,
  output logic [tnh_pkg::ADDR_W-1:0]           next_hop,
  output logic                                 status
);
  import tnh_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH);

  logic [ADDR_W-1:0]      local_address;
  logic [ADDR_W-1:0]      uplink_address;

  logic [ADDR_W-1:0]      node_addr [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] node_valid;
  logic [ADDR_W-1:0]      node_up   [TABLE_DEPTH];

  logic [ADDR_W-1:0]      addr;
  logic [CNT_W-1:0]       hop_cnt;
  logic [TABLE_DEPTH-1:0] match_vec;
  logic                   hit;
  logic [ADDR_W-1:0]      up_rd;

  logic                   pick_hit;
  logic [IDX_W-1:0]       pick_idx;
  logic [ADDR_W-1:0]      parent_val;
  logic                   idx_ok;
  logic [IDX_W-1:0]       wr_idx;

  logic [ADDR_W-1:0]      hop_res;
  logic                   stat_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_address  <= '0;
      uplink_address <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOCAL:  local_address  <= cfg_data;
        REG_UPLINK: uplink_address <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign idx_ok = (int'(entry_index) < TABLE_DEPTH);
  assign wr_idx = IDX_W'(entry_index);

  // Node addresses sit in flops so every slot compares at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_valid <= '0;
    end else if (cmd.tbl_write && idx_ok) begin
      node_valid[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tbl_write && idx_ok) begin
      node_addr[wr_idx] <= entry_node;
    end
  end

  // Parent memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.tbl_write && idx_ok) begin
      node_up[wr_idx] <= entry_parent;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick_en) begin
      up_rd <= node_up[pick_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match_en) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        match_vec[i] <= node_valid[i] && (node_addr[i] == addr) && (addr != '0);
      end
    end
  end

  // Lowest matching slot wins.
  always_comb begin
    pick_hit = 1'b0;
    pick_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        pick_hit = 1'b1;
        pick_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (cmd.pick_en) begin
      hit <= pick_hit;
    end
  end

  assign parent_val = hit ? up_rd : '0;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      addr    <= dest_address;
      hop_cnt <= '0;
    end else if (cmd.step_en) begin
      addr    <= parent_val;
      hop_cnt <= hop_cnt + CNT_W'(1);
    end
  end

  assign sts.req_op     = op;
  assign sts.req_sensor = is_sensor_data;
  assign sts.at_local   = (parent_val == local_address);
  assign sts.walk_over  = (parent_val == '0) || (hop_cnt == CNT_W'(TABLE_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        RES_ZERO_OK: begin
          hop_res  <= '0;
          stat_res <= STATUS_GOOD;
        end
        RES_UPLINK: begin
          hop_res  <= uplink_address;
          stat_res <= STATUS_GOOD;
        end
        RES_FOUND: begin
          hop_res  <= addr;
          stat_res <= STATUS_GOOD;
        end
        RES_NO_ROUTE: begin
          hop_res  <= '0;
          stat_res <= STATUS_NO_ROUTE;
        end
        default: begin
          hop_res  <= '0;
          stat_res <= STATUS_NO_ROUTE;
        end
      endcase
    end
  end

  // Output word register; holds while the sink stalls.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      next_hop <= hop_res;
      status   <= stat_res;
    end
  end

  `TNH_ASSERT(a_step_only_on_miss, clk, rst, cmd.step_en |-> !sts.at_local && !sts.walk_over, "walk advanced after it should have ended")
  `TNH_ASSERT(a_found_is_local, clk, rst, (cmd.res_load && cmd.res_sel == RES_FOUND) |-> (parent_val == local_address), "next hop taken without reaching local node")
  `TNH_ASSERT(a_count_restarts, clk, rst, cmd.load_item |=> hop_cnt == '0, "hop count not cleared for new item")

endmodule

`default_nettype wire

// ----- rtl/tnh_ctrl.sv -----
`default_nettype none

`include "assert_macros.svh"

module tnh_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  tnh_pkg::sts_t sts,
  output tnh_pkg::cmd_t cmd
);
  import tnh_pkg::*;

  state_t state;
  state_t state_next;
  logic   fire;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign fire     = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (fire) begin
          if (sts.req_op == OP_WRITE || sts.req_sensor) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_MATCH;
          end
        end
      end
      S_MATCH: state_next = S_PICK;
      S_PICK:  state_next = S_CHECK;
      S_CHECK: begin
        if (sts.at_local || sts.walk_over) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_MATCH;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.res_sel   = RES_ZERO_OK;
    unique case (state)
      S_IDLE: begin
        cmd.load_item = fire;
        if (fire) begin
          priority if (sts.req_op == OP_WRITE) begin
            cmd.tbl_write = 1'b1;
            cmd.res_load  = 1'b1;
            cmd.res_sel   = RES_ZERO_OK;
          end else if (sts.req_sensor) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_UPLINK;
          end else begin
            cmd.res_load = 1'b0;
          end
        end
      end
      S_MATCH: cmd.match_en = 1'b1;
      S_PICK:  cmd.pick_en  = 1'b1;
      S_CHECK: begin
        priority if (sts.at_local) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_FOUND;
        end else if (sts.walk_over) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_NO_ROUTE;
        end else begin
          cmd.step_en = 1'b1;
        end
      end
      S_EMIT:  cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `TNH_ASSERT(a_no_overwrite, clk, rst, cmd.out_load |-> (!out_valid || out_ready), "result word overwritten before it was taken")
  `TNH_ASSERT(a_check_after_pick, clk, rst, state == S_CHECK |-> $past(state) == S_PICK, "hop check without a table read")
  `TNH_ASSERT_ALWAYS(a_one_table_phase, clk, $onehot0({cmd.match_en, cmd.pick_en, cmd.step_en, cmd.tbl_write}), "table phases overlap")

endmodule

`default_nettype wire

// ----- rtl/tree_next_hop_lookup_core.sv -----
`default_nettype none

// Next-hop lookup for a tree network. Write words (op 0) load a (node,
// parent) pair into a table slot; slots at or beyond TABLE_DEPTH are
// ignored, and all slots are empty after reset. A route word (op 1) for
// sensor data returns uplink_address at once. Any other route word walks
// up the tree from dest_address until it finds a node whose parent is
// local_address and returns that node; a missed lookup or TABLE_DEPTH
// hops without success give next_hop 0 and status 1, but with
// local_address 0 a miss returns the looked-up address. Every input
// word yields exactly one result word. A write or sensor word skips the
// walk; each hop of a walk runs the states match (parallel compare of
// all node addresses), pick (first-match pick with a parent memory
// read) and check. One word is in flight at a time; the next word can
// be accepted the cycle after the result moves to the output register,
// even if the sink has not yet taken it.
module tree_next_hop_lookup_core #(
  parameter int TABLE_DEPTH = tnh_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tnh_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tnh_pkg::ADDR_W-1:0]      cfg_data,
  tnh_in_if.sink                          req,
  tnh_out_if.source                       rsp
);
  import tnh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tnh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tnh_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .op             (req.op),
    .entry_index    (req.entry_index),
    .entry_node     (req.entry_node),
    .entry_parent   (req.entry_parent),
    .dest_address   (req.dest_address),
    .is_sensor_data (req.is_sensor_data),
    .cmd            (cmd),
    .sts            (sts),
    .next_hop       (rsp.next_hop),
    .status         (rsp.status)
  );

endmodule

`default_nettype wire

// ----- sim/tree_next_hop_lookup_core_test.sv -----
`default_nettype none

module tree_next_hop_lookup_core_test;
  import tnh_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int PHASE_WORDS = 122;

  typedef struct packed {
    logic               op;
    logic [INDEX_W-1:0] slot;
    logic [ADDR_W-1:0]  node;
    logic [ADDR_W-1:0]  parent;
    logic [ADDR_W-1:0]  dest;
    logic               sensor;
  } req_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] next_hop;
    logic              status;
  } hop_result_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]      cfg_data;

  tnh_in_if  req_ch ();
  tnh_out_if rsp_ch ();

  tree_next_hop_lookup_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #10 clk = ~clk;

  // Shadow of the routing table and registers.
  logic [ADDR_W-1:0] node_tbl   [DEPTH];
  logic [ADDR_W-1:0] parent_tbl [DEPTH];
  logic [ADDR_W-1:0] local_addr;
  logic [ADDR_W-1:0] uplink_addr;

  req_word_t   pending_words [$];
  hop_result_t expected_hops [$];

  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic word_taken = 1'b0;
  int   words_queued = 0;
  int   words_accepted = 0;
  int   results_seen = 0;
  int   mismatches = 0;
  int   n_writes = 0;
  int   n_sensor = 0;
  int   n_found = 0;
  int   n_no_route = 0;
  int   deepest = 0;

  function automatic logic [ADDR_W-1:0] parent_of(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] up;
    int i;
    up = '0;
    // Scan from the top so the lowest matching slot wins.
    if (addr != '0) begin
      for (i = DEPTH - 1; i >= 0; i--) begin
        if (node_tbl[i] == addr) up = parent_tbl[i];
      end
    end
    return up;
  endfunction

  function automatic hop_result_t predict_hop(input req_word_t w);
    hop_result_t       r;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] up;
    logic              done;
    logic              found;
    int                n;
    r.next_hop = '0;
    r.status = STATUS_GOOD;
    if (w.op == OP_WRITE) begin
      if (int'(w.slot) < DEPTH) begin
        node_tbl[w.slot] = w.node;
        parent_tbl[w.slot] = w.parent;
      end
      n_writes++;
    end else if (w.sensor) begin
      r.next_hop = uplink_addr;
      n_sensor++;
    end else begin
      addr = w.dest;
      done = 1'b0;
      found = 1'b0;
      // Climb until the parent is this node; give up on a miss (unless the local address is zero) or after DEPTH hops.
      for (n = 0; n < DEPTH && !done; n++) begin
        up = parent_of(addr);
        if (up == local_addr) begin
          found = 1'b1;
          done = 1'b1;
        end else begin
          addr = up;
          if (addr == '0) done = 1'b1;
        end
      end
      if (found) begin
        r.next_hop = addr;
        n_found++;
        if (n > deepest) deepest = n;
      end else begin
        r.status = STATUS_NO_ROUTE;
        n_no_route++;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 20) $display("mismatch: %s", msg);
  endtask

  task automatic push_write(input int slot, input logic [ADDR_W-1:0] node,
                            input logic [ADDR_W-1:0] parent);
    req_word_t w;
    w.op = OP_WRITE;
    w.slot = slot[INDEX_W-1:0];
    w.node = node;
    w.parent = parent;
    w.dest = ADDR_W'($urandom_range(65535));
    w.sensor = 1'($urandom_range(1));
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic push_route(input logic [ADDR_W-1:0] dest, input logic sensor);
    req_word_t w;
    w.op = OP_ROUTE;
    w.slot = INDEX_W'($urandom_range(DEPTH - 1));
    w.node = ADDR_W'($urandom_range(65535));
    w.parent = ADDR_W'($urandom_range(65535));
    w.dest = dest;
    w.sensor = sensor;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [ADDR_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LOCAL) local_addr = val;
    else uplink_addr = val;
  endtask

  task automatic wait_drain();
    while (words_accepted != words_queued || expected_hops.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Request driver: hold a word until taken, then maybe idle.
  always @(negedge clk) begin : drive
    req_word_t w;
    if (!(req_ch.valid && !word_taken)) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending_words.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.op <= w.op;
        req_ch.entry_index <= w.slot;
        req_ch.entry_node <= w.node;
        req_ch.entry_parent <= w.parent;
        req_ch.dest_address <= w.dest;
        req_ch.is_sensor_data <= w.sensor;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin : observe
    req_word_t   w;
    hop_result_t e;
    word_taken <= req_ch.valid && req_ch.ready;
    if (!rst && req_ch.valid && req_ch.ready) begin
      w.op = req_ch.op;
      w.slot = req_ch.entry_index;
      w.node = req_ch.entry_node;
      w.parent = req_ch.entry_parent;
      w.dest = req_ch.dest_address;
      w.sensor = req_ch.is_sensor_data;
      expected_hops.push_back(predict_hop(w));
      words_accepted++;
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (expected_hops.size() == 0) begin
        report_mismatch($sformatf("result %0d (next_hop %h) with nothing pending",
                                  results_seen, rsp_ch.next_hop));
      end else begin
        e = expected_hops.pop_front();
        if (rsp_ch.next_hop !== e.next_hop)
          report_mismatch($sformatf("result %0d next_hop %h, want %h",
                                    results_seen, rsp_ch.next_hop, e.next_hop));
        if (rsp_ch.status !== e.status)
          report_mismatch($sformatf("result %0d status %b, want %b",
                                    results_seen, rsp_ch.status, e.status));
      end
    end
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] branch [$];
    logic [ADDR_W-1:0] up;
    int sub, k, m, base, target, i, r;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.op = OP_WRITE;
    req_ch.entry_index = '0;
    req_ch.entry_node = '0;
    req_ch.entry_parent = '0;
    req_ch.dest_address = '0;
    req_ch.is_sensor_data = 1'b0;
    rsp_ch.ready = 1'b0;
    for (i = 0; i < DEPTH; i++) begin
      node_tbl[i] = '0;
      parent_tbl[i] = '0;
    end
    local_addr = '0;
    uplink_addr = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset registers: local address zero, so a miss returns the looked-up address.
    push_route(16'h9C3A, 1'b1);
    push_route(16'h5555, 1'b0);
    push_route(16'h0000, 1'b0);
    wait_drain();

    write_reg(REG_LOCAL, 16'hFFFF);
    write_reg(REG_UPLINK, 16'hA5A5);
    push_write(0, 16'h0000, 16'hFFFF);
    push_write(31, 16'h0001, 16'hFFFF);
    push_write(1, 16'h8000, 16'h0001);
    push_write(2, 16'h8000, 16'h1111);
    push_route(16'h8000, 1'b0);
    push_route(16'h0001, 1'b0);
    push_route(16'h0000, 1'b0);
    push_route(16'h7777, 1'b0);
    push_write(3, 16'h2222, 16'h3333);
    push_write(4, 16'h3333, 16'h2222);
    push_route(16'h2222, 1'b0);
    push_route(16'h8000, 1'b1);
    push_route(16'hFFFF, 1'b0);
    wait_drain();

    for (sub = 0; sub < 8; sub++) begin
      case (sub / 2)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 86; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 86; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      case (sub)
        0: begin write_reg(REG_LOCAL, 16'h0000); write_reg(REG_UPLINK, 16'hFFFF); end
        1: begin write_reg(REG_LOCAL, 16'hFFFF); write_reg(REG_UPLINK, 16'h0000); end
        2: begin write_reg(REG_LOCAL, 16'h8000); write_reg(REG_UPLINK, 16'h7FFF); end
        default: begin
          write_reg(REG_LOCAL, ADDR_W'($urandom_range(65535, 1)));
          write_reg(REG_UPLINK, ADDR_W'($urandom_range(65535)));
        end
      endcase
      target = words_queued + PHASE_WORDS;
      while (words_queued < target) begin
        // Load a subtree below this node, or now and then a full-depth chain.
        r = $urandom_range(9);
        k = (r == 0) ? DEPTH : $urandom_range(12, 2);
        base = $urandom_range(DEPTH - 1);
        branch.delete();
        for (i = 0; i < k; i++) branch.push_back(ADDR_W'($urandom_range(65535, 1)));
        for (i = 0; i < k; i++) begin
          if (r == 0) begin
            if (i < k - 1) up = branch[i + 1];
            else if ($urandom_range(1)) up = local_addr;
            else up = branch[$urandom_range(k - 2)];
          end else if (i == 0 || $urandom_range(3) == 0) begin
            up = local_addr;
          end else if ($urandom_range(1)) begin
            up = branch[i - 1];
          end else begin
            up = branch[$urandom_range(i - 1)];
          end
          push_write((base + i) % DEPTH, branch[i], up);
        end
        m = $urandom_range(10, 3);
        for (i = 0; i < m; i++) begin
          if (r == 0 && i == 0) begin
            push_route(branch[0], 1'b0);
          end else begin
            case ($urandom_range(19))
              0, 1: push_route(ADDR_W'($urandom_range(65535)), 1'b1);
              2: push_route(16'h0000, 1'b0);
              3, 4: push_route(ADDR_W'($urandom_range(65535)), 1'b0);
              5: push_write($urandom_range(DEPTH - 1), ADDR_W'($urandom_range(65535)),
                            branch[$urandom_range(k - 1)]);
              default: push_route(branch[$urandom_range(k - 1)], 1'b0);
            endcase
          end
        end
      end
      wait_drain();
    end

    // Watch for stray results over one worst-case walk.
    repeat (2 + 3 * DEPTH) @(negedge clk);
    $display("%0d words: %0d table writes, %0d sensor routes, %0d walks found %s",
             words_accepted, n_writes, n_sensor, n_found,
             $sformatf("(deepest %0d hops), %0d no route", deepest, n_no_route));
    $display("8 register settings across four idle/stall mixes, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
